// File: sv/kfs_pkg.sv
// Shared types, widths, register indexes and reset values of the scalar Kalman filter step.
// No dependencies; kfs_if.sv and scalar_kalman_filter_step.sv import this package.
`timescale 1ns / 1ps

package kfs_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int VAL_W      = 48;
    localparam int COV_W      = 32;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic [COV_W-1:0]         t_cov;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    localparam t_cfg_idx REG_STEP_AMOUNT        = 3'd0;
    localparam t_cfg_idx REG_PROCESS_NOISE      = 3'd1;
    localparam t_cfg_idx REG_MEASUREMENT_NOISE  = 3'd2;
    localparam t_cfg_idx REG_INITIAL_ESTIMATE   = 3'd3;
    localparam t_cfg_idx REG_INITIAL_COVARIANCE = 3'd4;

    localparam t_cov   RST_STEP_AMOUNT        = 32'd6554;
    localparam t_cov   RST_PROCESS_NOISE      = 32'd655360;
    localparam t_cov   RST_MEASUREMENT_NOISE  = 32'd655;
    localparam t_value RST_INITIAL_ESTIMATE   = 48'sd11796480000;
    localparam t_cov   RST_INITIAL_COVARIANCE = 32'd655;

    localparam t_value VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

// File: sv/kfs_if.sv
// Valid/ready channel interfaces for the measurement input and the filter result.
// Depends on kfs_pkg for the payload types.
`timescale 1ns / 1ps

interface kfs_meas_if;
    import kfs_pkg::*;

    logic   valid;
    logic   ready;
    t_value measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface kfs_result_if;
    import kfs_pkg::*;

    logic   valid;
    logic   ready;
    t_value estimate;
    t_cov   covariance;
    t_gain  gain;

    modport source (output valid, output estimate, output covariance, output gain, input ready);
    modport sink   (input valid, input estimate, input covariance, input gain, output ready);
endinterface

// File: sv/scalar_kalman_filter_step.sv
// Top level of the scalar Kalman filter step: predict, serial gain divide, serial updates.
// Depends on kfs_pkg, kfs_if.sv, kfs_div and kfs_mul.
//
//   Port       Dir  Handshake      Carries
//   i_meas     in   valid/ready    measurement
//   o_result   out  valid/ready    estimate, covariance, gain
//   i_cfg_*    in   write enable   register index and write data
//
// One transaction runs from acceptance through predict, prepare, divide, multiply and finish
// back to idle; the serial divider and the two serial multipliers each work through the
// gain one bit at a time. A finished result waits in the output register while the
// next measurement is accepted; only a second finished result stalls behind it.
// Reset is synchronous and loads the register defaults and the initial state.
`timescale 1ns / 1ps

module scalar_kalman_filter_step #(
    parameter int FRACTION_BITS = kfs_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  kfs_pkg::t_cfg_idx   i_cfg_idx,
    input  kfs_pkg::t_cfg_data  i_cfg_data,
    kfs_meas_if.sink            i_meas,
    kfs_result_if.source        o_result
);
    import kfs_pkg::*;

    localparam int GQ_W  = FRACTION_BITS + 1;
    localparam int DEN_W = COV_W + 1;
    localparam int MAG_W = VAL_W + 1;
    localparam int EXT_W = VAL_W + 2;

    localparam logic [GQ_W-1:0] ONE_FX = GQ_W'(1) << FRACTION_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       r_state;
    t_cov             r_step;
    t_cov             r_pnoise;
    t_cov             r_mnoise;
    t_value           r_est;
    t_cov             r_cov;
    t_value           r_z;
    t_value           r_xp;
    t_cov             r_pp;
    logic             r_dz;
    logic             r_neg;
    logic [MAG_W-1:0] r_mag;
    logic [GQ_W-1:0]  r_gain;
    logic             r_ov;
    t_value           r_out_est;
    t_cov             r_out_cov;
    t_gain            r_out_gain;

    logic [EXT_W-1:0] n_xp_ext;
    t_value           n_xp;
    logic [DEN_W-1:0] n_pp_sum;
    t_cov             n_pp;
    logic [DEN_W-1:0] n_den;
    logic [MAG_W-1:0] n_innov;
    logic [GQ_W-1:0]  n_gain;
    logic [EXT_W-1:0] n_xn_ext;
    t_value           n_xn;
    logic             n_out_free;

    logic             div_done;
    logic [GQ_W-1:0]  div_quot;
    logic             mul_e_done;
    logic [MAG_W:0]   mul_e_prod;
    logic             mul_p_done;
    logic [COV_W:0]   mul_p_prod;

    always_comb begin
        n_xp_ext = {{2{r_est[VAL_W-1]}}, r_est} - {{(EXT_W-COV_W){1'b0}}, r_step};
        if (n_xp_ext[EXT_W-1:VAL_W-1] == '0 || n_xp_ext[EXT_W-1:VAL_W-1] == '1) begin
            n_xp = n_xp_ext[VAL_W-1:0];
        end else if (n_xp_ext[EXT_W-1]) begin
            n_xp = VAL_MIN;
        end else begin
            n_xp = VAL_MAX;
        end

        n_pp_sum = {1'b0, r_cov} + {1'b0, r_pnoise};
        n_pp     = n_pp_sum[COV_W] ? '1 : n_pp_sum[COV_W-1:0];

        n_den   = {1'b0, r_pp} + {1'b0, r_mnoise};
        n_innov = {r_z[VAL_W-1], r_z} - {r_xp[VAL_W-1], r_xp};

        n_gain = r_dz ? '0 : div_quot;

        n_xn_ext = r_neg
            ? ({{2{r_xp[VAL_W-1]}}, r_xp} - {1'b0, mul_e_prod[MAG_W-1:0]})
            : ({{2{r_xp[VAL_W-1]}}, r_xp} + {1'b0, mul_e_prod[MAG_W-1:0]});
        if (n_xn_ext[EXT_W-1:VAL_W-1] == '0 || n_xn_ext[EXT_W-1:VAL_W-1] == '1) begin
            n_xn = n_xn_ext[VAL_W-1:0];
        end else if (n_xn_ext[EXT_W-1]) begin
            n_xn = VAL_MIN;
        end else begin
            n_xn = VAL_MAX;
        end

        n_out_free = !r_ov || o_result.ready;
    end

    kfs_div #(
        .W  (DEN_W),
        .QW (GQ_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   ({1'b0, r_pp}),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    kfs_mul #(
        .AW (MAG_W),
        .BW (GQ_W)
    ) u_mul_est (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV && div_done),
        .i_a     (r_mag),
        .i_b     (n_gain),
        .o_done  (mul_e_done),
        .o_prod  (mul_e_prod)
    );

    kfs_mul #(
        .AW (COV_W),
        .BW (GQ_W)
    ) u_mul_cov (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV && div_done),
        .i_a     (r_pp),
        .i_b     (ONE_FX - n_gain),
        .o_done  (mul_p_done),
        .o_prod  (mul_p_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= RST_STEP_AMOUNT;
            r_pnoise <= RST_PROCESS_NOISE;
            r_mnoise <= RST_MEASUREMENT_NOISE;
            r_est    <= RST_INITIAL_ESTIMATE;
            r_cov    <= RST_INITIAL_COVARIANCE;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_FIN && n_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_meas.valid) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_e_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_est   <= n_xn;
                        r_cov   <= mul_p_prod[COV_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_STEP_AMOUNT:        r_step   <= i_cfg_data[COV_W-1:0];
                    REG_PROCESS_NOISE:      r_pnoise <= i_cfg_data[COV_W-1:0];
                    REG_MEASUREMENT_NOISE:  r_mnoise <= i_cfg_data[COV_W-1:0];
                    REG_INITIAL_ESTIMATE:   r_est    <= i_cfg_data[VAL_W-1:0];
                    REG_INITIAL_COVARIANCE: r_cov    <= i_cfg_data[COV_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_meas.valid) begin
            r_z <= i_meas.measurement;
        end
        if (r_state == S_PRED) begin
            r_xp <= n_xp;
            r_pp <= n_pp;
        end
        if (r_state == S_PREP) begin
            r_dz  <= (n_den == '0);
            r_neg <= n_innov[MAG_W-1];
            r_mag <= n_innov[MAG_W-1] ? (MAG_W'(0) - n_innov) : n_innov;
        end
        if (r_state == S_DIV && div_done) begin
            r_gain <= n_gain;
        end
        if (r_state == S_FIN && n_out_free) begin
            r_out_est  <= n_xn;
            r_out_cov  <= mul_p_prod[COV_W-1:0];
            r_out_gain <= GAIN_W'(r_gain);
        end
    end

    assign i_meas.ready        = (r_state == S_IDLE);
    assign o_result.valid      = r_ov;
    assign o_result.estimate   = r_out_est;
    assign o_result.covariance = r_out_cov;
    assign o_result.gain       = r_out_gain;

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide phase.");
    a_mul_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_e_done == mul_p_done)
        else $error("The two multipliers finished apart.");
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_gain <= ONE_FX))
        else $error("Gain exceeds one.");
    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (mul_p_prod <= {1'b0, r_pp}))
        else $error("Updated covariance exceeds the predicted covariance.");
endmodule

// File: sv/kfs_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, most significant bit first.
// Computes floor(num * 2^(QW-1) / den) for num <= den. Depends on kfs_pkg only by convention.
`timescale 1ns / 1ps

module kfs_div #(
    parameter int W  = 33,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    localparam int CNT_W = $clog2(QW + 1);

    logic [W:0]       r_rem;
    logic [W-1:0]     r_den;
    logic [QW-1:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             n_ge;
    logic [W:0]       n_sub;

    always_comb begin
        n_ge  = (r_rem >= {1'b0, r_den});
        n_sub = n_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[QW-2:0], n_ge};
            r_rem  <= {n_sub[W-1:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_den != '0) |-> (r_rem < {r_den, 1'b0}))
        else $error("Divider remainder left its bound.");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Divider done lasted more than one cycle.");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("Divider finished without running.");
endmodule

// File: sv/kfs_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, least significant first.
// Computes floor(a * b / 2^(BW-1)) exactly. Depends on kfs_pkg only by convention.
`timescale 1ns / 1ps

module kfs_mul #(
    parameter int AW = 32,
    parameter int BW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic          o_done,
    output logic [AW:0]   o_prod
);
    localparam int CNT_W = $clog2(BW + 1);

    logic [AW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [AW:0]      r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [AW:0]      n_sum;

    assign n_sum = r_acc + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(BW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b <= r_b >> 1;
            if (r_cnt == CNT_W'(1)) begin
                r_acc <= n_sum;
            end else begin
                r_acc <= n_sum >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != CNT_W'(BW)) |-> (r_acc <= {1'b0, r_a}))
        else $error("Multiplier accumulator exceeded the multiplicand.");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Multiplier done lasted more than one cycle.");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("Multiplier finished without running.");
endmodule
